FILE: hdl/rfr_pkg.sv
// rfr_pkg: shared types, constants and pointer helpers for the ring fifo with reverse
// used by rfr_ram, rfr_mod and ring_fifo_with_reverse; no dependencies
package rfr_pkg;

  // ring geometry and field widths
  localparam int DEPTH      = 1024;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int VALUE_BITS = 32;
  localparam int OFS_W      = 32;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;

  // iterative remainder unit: one dividend bit per step
  localparam int DIV_STEPS  = OFS_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FRONT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [VALUE_BITS-1:0] value_in;
    logic [OFS_W-1:0]      offset;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      count;
    logic                  empty_res;
    logic [STAT_W-1:0]     status;
  } res_t;

  // remainder unit request and response
  typedef struct packed {
    logic             go;
    logic [OFS_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_REV_A,
    ST_REV_B,
    ST_REV_C,
    ST_REV_D,
    ST_RESP
  } state_t;

  // step a pointer forward round the ring
  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] s;
    s = {1'b0, p} + CNT_W'(1);
    return (s >= cap) ? '0 : s[PTR_W-1:0];
  endfunction

  // step a pointer backward round the ring
  function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] s;
    s = cap - CNT_W'(1);
    return (p == '0) ? s[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

endpackage

FILE: hdl/rfr_ram.sv
// rfr_ram: ring storage, one write port and one read port with registered read data
// depends on rfr_pkg
module rfr_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [rfr_pkg::PTR_W-1:0]        waddr,
  input  logic [rfr_pkg::VALUE_BITS-1:0]   wdata,
  input  logic                             re,
  input  logic [rfr_pkg::PTR_W-1:0]        raddr,
  output logic [rfr_pkg::VALUE_BITS-1:0]   rdata
);

  logic [rfr_pkg::VALUE_BITS-1:0] mem [rfr_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rfr_mod.sv
// rfr_mod: iterative restoring remainder, one dividend bit per cycle
// depends on rfr_pkg
module rfr_mod (
  input  logic               clk,
  input  logic               rst,
  input  rfr_pkg::mod_req_t  mreq,
  output rfr_pkg::mod_rsp_t  mrsp
);

  logic                        running;
  logic [rfr_pkg::STEP_W-1:0]  steps;
  logic [rfr_pkg::OFS_W-1:0]   dvd;
  logic [rfr_pkg::CNT_W-1:0]   divisor;
  logic [rfr_pkg::CNT_W-1:0]   rem;
  logic [rfr_pkg::CNT_W:0]     trial;
  logic [rfr_pkg::CNT_W:0]     rem_next;
  logic                        done;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, dvd[rfr_pkg::OFS_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= running && (steps == '0);
      if (mreq.go) begin
        running <= 1'b1;
        steps   <= rfr_pkg::STEP_W'(rfr_pkg::DIV_STEPS - 1);
      end else if (running) begin
        if (steps == '0) begin
          running <= 1'b0;
        end
        steps <= steps - rfr_pkg::STEP_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mreq.go) begin
      dvd     <= mreq.dividend;
      divisor <= mreq.divisor;
      rem     <= '0;
    end else if (running) begin
      dvd <= {dvd[rfr_pkg::OFS_W-2:0], 1'b0};
      rem <= rem_next[rfr_pkg::CNT_W-1:0];
    end
  end

  assign mrsp.done = done;
  assign mrsp.rem  = rem;

endmodule

FILE: hdl/ring_fifo_with_reverse.sv
// ring_fifo_with_reverse: top level, request sequencer and pointer state
// depends on rfr_pkg, rfr_ram and rfr_mod
//
// Usage
//   A request transfers on a rising edge with start high and busy low; busy
//   then stays high until the result has been shown. Each request gives one
//   result on res, valid for exactly one cycle while done is high. The
//   receiver cannot stall, so it must take res whenever done is high.
//   The capacity register is written over cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is high only while the block is idle and no start is raised.
//   A write clamps the value into 1..1024 and empties the queue.
// Sequence, from the transfer to the done cycle
//   push, pop, front and unused codes: done in the next cycle, after one ram access
//   reverse: each of the floor(count / 2) swapped pairs takes two reads and
//     two writes (ST_REV_A to ST_REV_D) through the single read and write ports
//   read at offset: the remainder unit takes one of the 32 offset bits per
//     cycle in ST_DIV, then ST_IDX forms the ring address and reads the ram
//   A new request may start in the cycle after done.
// Reset
//   rst (synchronous) empties the queue and sets capacity to 1024; the
//   ring contents are not cleared and are never read before being written.
module ring_fifo_with_reverse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rfr_pkg::req_t                req,
  output logic                         done,
  output rfr_pkg::res_t                res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rfr_pkg::CNT_W-1:0]    cfg_data
);

  rfr_pkg::state_t state, state_next;

  logic [rfr_pkg::PTR_W-1:0]      head;
  logic [rfr_pkg::PTR_W-1:0]      tail;
  logic [rfr_pkg::CNT_W-1:0]      fill;
  logic [rfr_pkg::CNT_W-1:0]      capacity;
  logic [rfr_pkg::CNT_W-1:0]      cap_next;
  logic [rfr_pkg::PTR_W-1:0]      lo;
  logic [rfr_pkg::PTR_W-1:0]      hi;
  logic [rfr_pkg::PTR_W-1:0]      pairs;
  logic [rfr_pkg::VALUE_BITS-1:0] tmp;
  logic [rfr_pkg::CNT_W-1:0]      idx_sum;
  logic [rfr_pkg::CNT_W-1:0]      idx_wrap;
  logic [rfr_pkg::STAT_W-1:0]     status;
  logic                           use_mem;

  logic                           accept;
  logic                           cfg_wr;
  logic                           is_empty;
  logic                           is_full;
  logic [rfr_pkg::PTR_W-1:0]      push_addr;

  logic                           ram_we;
  logic [rfr_pkg::PTR_W-1:0]      ram_waddr;
  logic [rfr_pkg::VALUE_BITS-1:0] ram_wdata;
  logic                           ram_re;
  logic [rfr_pkg::PTR_W-1:0]      ram_raddr;
  logic [rfr_pkg::VALUE_BITS-1:0] ram_rdata;

  rfr_pkg::mod_req_t mod_req;
  rfr_pkg::mod_rsp_t mod_rsp;

  rfr_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfr_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .mreq (mod_req),
    .mrsp (mod_rsp)
  );

  // handshakes
  assign busy      = (state != rfr_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign is_empty  = (fill == '0);
  assign is_full   = (fill >= capacity);
  assign push_addr = is_empty ? '0 : rfr_pkg::wrap_next(tail, capacity);

  // ring address for read at offset: one conditional subtract
  assign idx_wrap = (idx_sum >= capacity) ? idx_sum - capacity : idx_sum;

  // capacity clamp
  always_comb begin
    if (cfg_data == '0) begin
      cap_next = rfr_pkg::CNT_W'(1);
    end else if (cfg_data > rfr_pkg::CNT_W'(rfr_pkg::DEPTH)) begin
      cap_next = rfr_pkg::CNT_W'(rfr_pkg::DEPTH);
    end else begin
      cap_next = cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rfr_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.req_type == rfr_pkg::REQ_READ && !is_empty) begin
            state_next = rfr_pkg::ST_DIV;
          end else if (req.req_type == rfr_pkg::REQ_REVERSE && fill > rfr_pkg::CNT_W'(1)) begin
            state_next = rfr_pkg::ST_REV_A;
          end else begin
            state_next = rfr_pkg::ST_RESP;
          end
        end
      end
      rfr_pkg::ST_DIV: begin
        if (mod_rsp.done) begin
          state_next = rfr_pkg::ST_IDX;
        end
      end
      rfr_pkg::ST_IDX:   state_next = rfr_pkg::ST_RESP;
      rfr_pkg::ST_REV_A: state_next = rfr_pkg::ST_REV_B;
      rfr_pkg::ST_REV_B: state_next = rfr_pkg::ST_REV_C;
      rfr_pkg::ST_REV_C: state_next = rfr_pkg::ST_REV_D;
      rfr_pkg::ST_REV_D: begin
        if (pairs == rfr_pkg::PTR_W'(1)) begin
          state_next = rfr_pkg::ST_RESP;
        end else begin
          state_next = rfr_pkg::ST_REV_A;
        end
      end
      rfr_pkg::ST_RESP:  state_next = rfr_pkg::ST_IDLE;
      default:           state_next = rfr_pkg::ST_IDLE;
    endcase
  end

  // ram and remainder unit controls
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = push_addr;
    ram_wdata        = req.value_in;
    ram_re           = 1'b0;
    ram_raddr        = head;
    mod_req.go       = 1'b0;
    mod_req.dividend = req.offset;
    mod_req.divisor  = fill;
    case (state)
      rfr_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            rfr_pkg::REQ_PUSH:  ram_we = !is_full;
            rfr_pkg::REQ_POP,
            rfr_pkg::REQ_FRONT: ram_re = !is_empty;
            rfr_pkg::REQ_READ:  mod_req.go = !is_empty;
            default:            ram_we = 1'b0;
          endcase
        end
      end
      rfr_pkg::ST_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx_wrap[rfr_pkg::PTR_W-1:0];
      end
      rfr_pkg::ST_REV_A: begin
        ram_re    = 1'b1;
        ram_raddr = lo;
      end
      rfr_pkg::ST_REV_B: begin
        ram_re    = 1'b1;
        ram_raddr = hi;
      end
      rfr_pkg::ST_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      rfr_pkg::ST_REV_D: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = tmp;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue pointers, count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      capacity <= rfr_pkg::CNT_W'(rfr_pkg::DEPTH);
    end else if (cfg_wr) begin
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      capacity <= cap_next;
    end else if (accept) begin
      if (req.req_type == rfr_pkg::REQ_PUSH && !is_full) begin
        tail <= push_addr;
        fill <= fill + rfr_pkg::CNT_W'(1);
      end else if (req.req_type == rfr_pkg::REQ_POP && !is_empty) begin
        fill <= fill - rfr_pkg::CNT_W'(1);
        if (fill == rfr_pkg::CNT_W'(1)) begin
          head <= '0;
          tail <= '0;
        end else begin
          head <= rfr_pkg::wrap_next(head, capacity);
        end
      end
    end
  end

  // request working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lo      <= head;
      hi      <= tail;
      pairs   <= fill[rfr_pkg::CNT_W-1:1];
      use_mem <= !is_empty && (req.req_type inside {rfr_pkg::REQ_POP, rfr_pkg::REQ_FRONT,
                                                    rfr_pkg::REQ_READ});
      if (req.req_type == rfr_pkg::REQ_PUSH && is_full) begin
        status <= rfr_pkg::STAT_FULL;
      end else if (is_empty && (req.req_type inside {rfr_pkg::REQ_POP, rfr_pkg::REQ_FRONT,
                                                     rfr_pkg::REQ_READ})) begin
        status <= rfr_pkg::STAT_EMPTY;
      end else begin
        status <= rfr_pkg::STAT_OK;
      end
    end
    if (state == rfr_pkg::ST_DIV && mod_rsp.done) begin
      idx_sum <= {1'b0, head} + mod_rsp.rem;
    end
    if (state == rfr_pkg::ST_REV_B) begin
      tmp <= ram_rdata;
    end
    if (state == rfr_pkg::ST_REV_D) begin
      lo    <= rfr_pkg::wrap_next(lo, capacity);
      hi    <= rfr_pkg::wrap_prev(hi, capacity);
      pairs <= pairs - rfr_pkg::PTR_W'(1);
    end
  end

  // result
  assign done          = (state == rfr_pkg::ST_RESP);
  assign res.value_out = use_mem ? ram_rdata : '0;
  assign res.count     = fill;
  assign res.empty_res = is_empty;
  assign res.status    = status;

  // checks
  a_fill_le_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= capacity)
    else $error("fill count exceeds capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> head == '0 && tail == '0)
    else $error("empty queue with non-zero pointers");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request transfer did not raise busy");

  a_mod_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == rfr_pkg::ST_DIV)
    else $error("remainder finished outside the divide state");

endmodule
